// File: hw/rtl/kcl_pkg.sv
// shared types, constants and codes for the keypad code lock
package kcl_pkg;

  // number of keys in one code and width of the tick timers
  localparam int CODE_DIGITS = 4;
  localparam int TIMER_BITS  = 16;

  // derived widths
  localparam int CODE_BITS  = CODE_DIGITS * 4;
  localparam int CNT_BITS   = $clog2(CODE_DIGITS + 1);
  localparam int LIMIT_BITS = 16;
  localparam int CMP_BITS   = (TIMER_BITS > LIMIT_BITS) ? TIMER_BITS : LIMIT_BITS;

  // register bank reset values
  localparam logic [15:0] LOCK_CODE_RST        = 16'h1234;
  localparam logic [15:0] IDLE_LIMIT_RST       = 16'd5000;
  localparam logic [15:0] ALARM_LENGTH_RST     = 16'd3000;
  localparam logic [3:0]  ATTEMPTS_ALLOWED_RST = 4'd3;

  // failure counter saturation value
  localparam logic [3:0] FAIL_MAX = 4'hF;

  // lock modes as shown on the result
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_ENTRY   = 2'd1,
    MODE_GRANTED = 2'd2,
    MODE_ALARM   = 2'd3
  } mode_t;

  // request kinds carried in tuser
  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_KEY      = 2'd1,
    REQ_PRESENCE = 2'd2
  } req_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_LOCK_CODE        = 2'd0,
    CFG_IDLE_LIMIT       = 2'd1,
    CFG_ALARM_LENGTH     = 2'd2,
    CFG_ATTEMPTS_ALLOWED = 2'd3
  } cfg_idx_t;

  // current register settings
  typedef struct packed {
    logic [15:0] lock_code;
    logic [15:0] idle_limit;
    logic [15:0] alarm_length;
    logic [3:0]  attempts_allowed;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic         code_rejected;
    logic         alarm_on;
    logic [3:0]   tries_left;
    logic [2:0]   digits_shown;
    logic [1:0]   lock_mode;
  } result_t;

  localparam int RESULT_BITS = $bits(result_t);

endpackage

// File: hw/rtl/kcl_cfg.sv
// configuration register bank of the keypad code lock
module kcl_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output kcl_pkg::cfg_t      cfg
);
  import kcl_pkg::*;

  cfg_t regs;

  // register writes, reset to the default code and limits
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.lock_code        <= LOCK_CODE_RST;
      regs.idle_limit       <= IDLE_LIMIT_RST;
      regs.alarm_length     <= ALARM_LENGTH_RST;
      regs.attempts_allowed <= ATTEMPTS_ALLOWED_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LOCK_CODE:        regs.lock_code        <= cfg_data;
        CFG_IDLE_LIMIT:       regs.idle_limit       <= cfg_data;
        CFG_ALARM_LENGTH:     regs.alarm_length     <= cfg_data;
        CFG_ATTEMPTS_ALLOWED: regs.attempts_allowed <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// File: hw/rtl/kcl_core.sv
// lock state machine, digit collection, timers and failure counter
module kcl_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [1:0]        req_type,
  input  logic [3:0]        key_code,
  input  kcl_pkg::cfg_t     cfg,
  output kcl_pkg::result_t  res
);
  import kcl_pkg::*;

  mode_t                 mode, mode_next;
  logic [CODE_BITS-1:0]  entered_digits, entered_digits_next;
  logic [CNT_BITS-1:0]   digit_count, digit_count_next;
  logic [3:0]            failure_count, failure_count_next;
  logic [TIMER_BITS-1:0] idle_timer, idle_timer_next;
  logic [TIMER_BITS-1:0] alarm_timer, alarm_timer_next;
  logic                  rejected;

  logic [TIMER_BITS-1:0] idle_inc, alarm_inc;
  logic [CODE_BITS-1:0]  shifted;
  logic [CNT_BITS-1:0]   count_inc;
  logic [3:0]            fail_inc;
  logic                  code_match;

  // saturating timer increments and the shifted-in digit
  assign idle_inc   = (idle_timer == '1) ? idle_timer : idle_timer + 1'b1;
  assign alarm_inc  = (alarm_timer == '1) ? alarm_timer : alarm_timer + 1'b1;
  assign shifted    = CODE_BITS'({entered_digits, key_code});
  assign count_inc  = digit_count + 1'b1;
  assign fail_inc   = (failure_count < FAIL_MAX) ? failure_count + 1'b1 : failure_count;
  assign code_match = (shifted == CODE_BITS'(cfg.lock_code));

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      entered_digits <= '0;
      digit_count    <= '0;
      failure_count  <= '0;
      idle_timer     <= '0;
      alarm_timer    <= '0;
    end else if (step) begin
      mode           <= mode_next;
      entered_digits <= entered_digits_next;
      digit_count    <= digit_count_next;
      failure_count  <= failure_count_next;
      idle_timer     <= idle_timer_next;
      alarm_timer    <= alarm_timer_next;
    end
  end

  // next state for one request
  always_comb begin
    mode_next           = mode;
    entered_digits_next = entered_digits;
    digit_count_next    = digit_count;
    failure_count_next  = failure_count;
    idle_timer_next     = idle_timer;
    alarm_timer_next    = alarm_timer;
    rejected            = 1'b0;
    unique case (req_t'(req_type))
      REQ_TICK: begin
        if (mode == MODE_ENTRY) begin
          if (CMP_BITS'(idle_inc) > CMP_BITS'(cfg.idle_limit)) begin
            // inactivity too long
            mode_next        = MODE_ALARM;
            alarm_timer_next = '0;
            idle_timer_next  = '0;
          end else begin
            idle_timer_next = idle_inc;
          end
        end else if (mode == MODE_ALARM) begin
          if (CMP_BITS'(alarm_inc) >= CMP_BITS'(cfg.alarm_length)) begin
            // alarm over, back to idle with a clean slate
            mode_next           = MODE_IDLE;
            failure_count_next  = '0;
            alarm_timer_next    = '0;
            idle_timer_next     = '0;
            entered_digits_next = '0;
            digit_count_next    = '0;
          end else begin
            alarm_timer_next = alarm_inc;
          end
        end
      end
      REQ_KEY: begin
        if (mode == MODE_ENTRY) begin
          entered_digits_next = shifted;
          digit_count_next    = count_inc;
          if (count_inc >= CNT_BITS'(CODE_DIGITS)) begin
            digit_count_next = CNT_BITS'(CODE_DIGITS);
            if (code_match) begin
              mode_next = MODE_GRANTED;
            end else begin
              rejected           = 1'b1;
              failure_count_next = fail_inc;
              if (fail_inc >= cfg.attempts_allowed) begin
                // last allowed failure used up
                mode_next        = MODE_ALARM;
                alarm_timer_next = '0;
                idle_timer_next  = '0;
              end else begin
                // retry: fresh entry
                entered_digits_next = '0;
                digit_count_next    = '0;
                idle_timer_next     = '0;
              end
            end
          end
        end
      end
      REQ_PRESENCE: begin
        if (mode == MODE_IDLE || mode == MODE_GRANTED) begin
          mode_next           = MODE_ENTRY;
          entered_digits_next = '0;
          digit_count_next    = '0;
          idle_timer_next     = '0;
        end
      end
      default: ;
    endcase
  end

  // result shows the state after the request
  always_comb begin
    res.lock_mode     = mode_next;
    res.digits_shown  = 3'(digit_count_next);
    res.tries_left    = (cfg.attempts_allowed > failure_count_next) ?
                        cfg.attempts_allowed - failure_count_next : 4'd0;
    res.alarm_on      = (mode_next == MODE_ALARM);
    res.code_rejected = rejected;
  end

  // a wrong code can only come from a key during entry
  a_reject_from_entry: assert property (@(posedge clk) disable iff (rst)
    step && rejected |-> mode == MODE_ENTRY && req_type == REQ_KEY)
    else $error("code rejected outside entry");

  // access is granted only by completing a code during entry
  a_grant_from_entry: assert property (@(posedge clk) disable iff (rst)
    step && mode != MODE_GRANTED ##1 mode == MODE_GRANTED |-> $past(mode) == MODE_ENTRY)
    else $error("access granted without entry");

  // the digit counter never passes the code length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    step |=> digit_count <= CNT_BITS'(CODE_DIGITS))
    else $error("digit count beyond code length");

  // a tick in idle leaves the lock idle
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    step && mode == MODE_IDLE && req_type == REQ_TICK |=> mode == MODE_IDLE)
    else $error("tick left idle");

endmodule

// File: hw/rtl/keypad_code_lock_with_alarm.sv
// top level of the keypad code lock with alarm
//
// Requests enter on the s_ stream: s_tuser carries the request kind
// (tick, key press, presence detected) and s_tdata the key code, used
// only for key presses. Every accepted request gives exactly one result
// on the m_ stream: lock mode, digits entered, tries left, alarm flag and
// a flag set when this key completed a wrong code.
// Registers (code, inactivity limit, alarm length, attempts allowed) are
// written through cfg_write/cfg_index/cfg_data; the user must write them only while no
// request is in flight, which the block itself does not enforce. A write takes effect at the next request.
// The state update and the result are computed in one pass from the
// request and the state registers, and the result is registered, so it
// appears in the cycle after the request is accepted. Throughput is one
// request per cycle; s_tready stays high while the result register is
// empty or being taken in the same cycle. If the receiver stalls, the
// result holds on m_tdata and s_tready drops until it is taken.
// Synchronous reset returns the lock to idle, clears digits, failures
// and timers, loads the default register values and empties the output.
module keypad_code_lock_with_alarm (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] key_code, [7:4] zero
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [1:0] lock_mode, [4:2] digits_shown,
                                 // [8:5] tries_left, [9] alarm_on,
                                 // [10] code_rejected, [15:11] zero
  // configuration writes
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import kcl_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_reg;
  logic    out_valid;
  logic    step;

  kcl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kcl_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .req_type (s_tuser),
    .key_code (s_tdata[3:0]),
    .cfg      (cfg),
    .res      (res)
  );

  // request accepted when the result register is free or draining
  assign s_tready = !out_valid || m_tready;
  assign step     = s_tvalid && s_tready;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_tready) begin
      out_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_reg <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(16 - RESULT_BITS)'(0), out_reg};

endmodule

// File: bench/kcl_result_check.sv
// result checker for the keypad code lock: predicts each result and compares it
`timescale 1ns / 1ps

module kcl_result_check
  import kcl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  localparam logic [15:0] TIMER_TOP = 16'hFFFF;

  // register copy and lock state as the block should hold them
  cfg_t        regs;
  mode_t       mode_q;
  logic [15:0] digits_q;
  logic [2:0]  count_q;
  logic [3:0]  fails_q;
  logic [15:0] idle_ticks;
  logic [15:0] alarm_ticks;

  // results predicted but not yet seen on the output
  result_t     awaited[$];

  function automatic void start_entry();
    mode_q     = MODE_ENTRY;
    digits_q   = '0;
    count_q    = '0;
    idle_ticks = '0;
  endfunction

  function automatic void start_alarm();
    mode_q      = MODE_ALARM;
    alarm_ticks = '0;
    idle_ticks  = '0;
  endfunction

  // apply one request to the lock state and return the result it shows
  function automatic result_t lock_step(logic [1:0] kind, logic [3:0] key);
    result_t res;
    logic    rejected;
    rejected = 1'b0;
    case (kind)
      REQ_TICK: begin
        if (mode_q == MODE_ENTRY) begin
          if (idle_ticks != TIMER_TOP) idle_ticks = idle_ticks + 1'b1;
          if (idle_ticks > regs.idle_limit) start_alarm();
        end else if (mode_q == MODE_ALARM) begin
          if (alarm_ticks != TIMER_TOP) alarm_ticks = alarm_ticks + 1'b1;
          if (alarm_ticks >= regs.alarm_length) begin
            mode_q      = MODE_IDLE;
            fails_q     = '0;
            alarm_ticks = '0;
            idle_ticks  = '0;
            digits_q    = '0;
            count_q     = '0;
          end
        end
      end
      REQ_KEY: begin
        if (mode_q == MODE_ENTRY) begin
          digits_q = {digits_q[11:0], key};
          count_q  = count_q + 1'b1;
          if (count_q >= 3'(CODE_DIGITS)) begin
            count_q = 3'(CODE_DIGITS);
            if (digits_q == regs.lock_code) begin
              mode_q = MODE_GRANTED;
            end else begin
              rejected = 1'b1;
              if (fails_q < FAIL_MAX) fails_q = fails_q + 1'b1;
              if (fails_q >= regs.attempts_allowed) start_alarm();
              else start_entry();
            end
          end
        end
      end
      REQ_PRESENCE: begin
        if (mode_q == MODE_IDLE || mode_q == MODE_GRANTED) start_entry();
      end
      default: ;
    endcase
    res.lock_mode     = mode_q;
    res.digits_shown  = count_q;
    res.tries_left    = (regs.attempts_allowed > fails_q) ?
                        regs.attempts_allowed - fails_q : 4'd0;
    res.alarm_on      = (mode_q == MODE_ALARM);
    res.code_rejected = rejected;
    return res;
  endfunction

  function automatic void report(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // watch both streams and the register port at every rising edge
  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      regs.lock_code        = LOCK_CODE_RST;
      regs.idle_limit       = IDLE_LIMIT_RST;
      regs.alarm_length     = ALARM_LENGTH_RST;
      regs.attempts_allowed = ATTEMPTS_ALLOWED_RST;
      mode_q      = MODE_IDLE;
      digits_q    = '0;
      count_q     = '0;
      fails_q     = '0;
      idle_ticks  = '0;
      alarm_ticks = '0;
      fail_count  = 0;
      checked     = 0;
      awaited.delete();
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          CFG_LOCK_CODE:        regs.lock_code        = cfg_data;
          CFG_IDLE_LIMIT:       regs.idle_limit       = cfg_data;
          CFG_ALARM_LENGTH:     regs.alarm_length     = cfg_data;
          CFG_ATTEMPTS_ALLOWED: regs.attempts_allowed = cfg_data[3:0];
          default: ;
        endcase
      end
      // result taken
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[RESULT_BITS-1:0]);
        if (awaited.size() == 0) begin
          report($sformatf("result 0x%04h with no request waiting", m_tdata));
        end else begin
          want = awaited.pop_front();
          checked++;
          if (got != want || m_tdata[15:RESULT_BITS] != '0)
            report($sformatf({"mode %0d/%0d digits %0d/%0d tries %0d/%0d ",
                              "alarm %0b/%0b rejected %0b/%0b pad %0h (want/got)"},
                             want.lock_mode, got.lock_mode,
                             want.digits_shown, got.digits_shown,
                             want.tries_left, got.tries_left,
                             want.alarm_on, got.alarm_on,
                             want.code_rejected, got.code_rejected,
                             m_tdata[15:RESULT_BITS]));
        end
      end
      // request accepted
      if (s_tvalid && s_tready) awaited.push_back(lock_step(s_tuser, s_tdata[3:0]));
    end
    pending = awaited.size();
  end

endmodule

// File: bench/tb_keypad_code_lock_with_alarm.sv
// testbench top for the keypad code lock: stimulus, register settings and verdict
`timescale 1ns / 1ps

module tb_keypad_code_lock_with_alarm;
  import kcl_pkg::*;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT  = 1_500_000;
  localparam int         RANDOM_ITEMS = 2000;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b1;
  logic [15:0] m_tdata;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  int fail_count;
  int pending;
  int checked;

  // stimulus bookkeeping
  bit          tx_full_rate = 1'b0;
  bit          rx_full_rate = 1'b0;
  int          rx_hold      = 0;
  int          sent         = 0;
  int          phases       = 0;
  int          cycles       = 0;
  logic [15:0] code_now     = LOCK_CODE_RST;

  always #1 clk = ~clk;

  keypad_code_lock_with_alarm u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  kcl_result_check u_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stalls
  always @(negedge clk) begin
    if (rst || rx_full_rate) begin
      m_tready = 1'b1;
      rx_hold  = 0;
    end else if (rx_hold > 0) begin
      m_tready = 1'b0;
      rx_hold--;
    end else if ($urandom_range(0, 99) < 70) begin
      m_tready = 1'b1;
    end else begin
      m_tready = 1'b0;
      rx_hold  = pick_gap();
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("tb_keypad_code_lock_with_alarm: done, errors");
      $finish;
    end
  end

  // one request, held until accepted; valid stays high on return
  task automatic send(logic [1:0] kind, logic [3:0] key);
    int gap;
    gap = tx_full_rate ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tdata  = {4'h0, key};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sent++;
  endtask

  // stop sending and wait until every result is back
  task automatic settle();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // load all four registers while the lock is quiet
  task automatic setup(logic [15:0] code, logic [15:0] lim, logic [15:0] alen,
                       logic [3:0] att);
    settle();
    write_reg(CFG_LOCK_CODE, code);
    write_reg(CFG_IDLE_LIMIT, lim);
    write_reg(CFG_ALARM_LENGTH, alen);
    write_reg(CFG_ATTEMPTS_ALLOWED, {12'h0, att});
    code_now = code;
    phases++;
  endtask

  task automatic keys(logic [15:0] code);
    for (int i = 3; i >= 0; i--) send(REQ_KEY, code[4*i +: 4]);
  endtask

  // presence then four keys, right or wrong, with a stray tick now and then
  task automatic try_code(bit good);
    logic [15:0] code;
    code = code_now;
    if (!good) begin
      if ($urandom_range(0, 1) == 0) code = 16'($urandom);
      else code = code ^ (16'($urandom_range(1, 15)) << (4 * $urandom_range(0, 3)));
    end
    send(REQ_PRESENCE, 4'($urandom));
    for (int i = 3; i >= 0; i--) begin
      if ($urandom_range(0, 9) == 0) send(REQ_TICK, 4'($urandom));
      send(REQ_KEY, code[4*i +: 4]);
    end
  endtask

  task automatic ticks(int n);
    repeat (n) send(REQ_TICK, 4'($urandom));
  endtask

  // one random register setting followed by a mix of sequences and noise
  task automatic random_phase(int n);
    logic [15:0] code, lim, alen;
    int          first, r;
    r = $urandom_range(0, 5);
    code = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
    r = $urandom_range(0, 7);
    lim  = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 15));
    r = $urandom_range(0, 7);
    alen = (r == 0) ? 16'h0000 : (r == 1) ? 16'd40 : 16'($urandom_range(1, 12));
    setup(code, lim, alen, 4'($urandom_range(0, 15)));
    tx_full_rate = ($urandom_range(0, 5) == 0);
    rx_full_rate = ($urandom_range(0, 5) == 0);
    first = sent;
    while (sent - first < n) begin
      r = $urandom_range(0, 99);
      if (r < 25) try_code(1'b1);
      else if (r < 55) try_code(1'b0);
      else if (r < 75) ticks($urandom_range(1, 16));
      else send(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
    end
    tx_full_rate = 1'b0;
    rx_full_rate = 1'b0;
  endtask

  initial begin
    int start_random;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // reset settings: out-of-place events, a good code, a wrong code
    send(REQ_UNUSED, 4'hF);
    send(REQ_KEY, 4'h5);
    send(REQ_TICK, 4'h0);
    send(REQ_PRESENCE, 4'h0);
    send(REQ_PRESENCE, 4'hA);
    keys(16'h1234);
    send(REQ_KEY, 4'h9);
    send(REQ_TICK, 4'h0);
    send(REQ_PRESENCE, 4'h0);
    keys(16'hFFFF);
    send(REQ_UNUSED, 4'h0);

    // zero inactivity limit, zero alarm length, zero attempts allowed
    setup(16'h0000, 16'h0000, 16'h0000, 4'd0);
    send(REQ_PRESENCE, 4'h0);
    send(REQ_TICK, 4'h0);
    send(REQ_PRESENCE, 4'h0);
    send(REQ_KEY, 4'h3);
    send(REQ_TICK, 4'h0);
    send(REQ_PRESENCE, 4'h0);
    keys(16'h0001);
    send(REQ_TICK, 4'h0);
    send(REQ_PRESENCE, 4'h0);
    keys(16'h0000);

    // small timers, all attempts allowed
    setup(16'hFFFF, 16'd2, 16'd3, 4'd15);
    send(REQ_PRESENCE, 4'h0);
    ticks(3);
    ticks(3);

    // limits at full scale: ticks run without alarming until a wrong code
    setup(16'hA5C3, 16'hFFFF, 16'hFFFF, 4'd1);
    tx_full_rate = 1'b1;
    rx_full_rate = 1'b1;
    send(REQ_PRESENCE, 4'h0);
    ticks(40);
    keys(16'h5A3C);
    ticks(40);
    tx_full_rate = 1'b0;
    rx_full_rate = 1'b0;

    // random phases
    start_random = sent;
    while (sent - start_random < RANDOM_ITEMS) random_phase($urandom_range(60, 140));

    settle();
    repeat (4) @(negedge clk);
    $display("%0d requests over %0d register settings, %0d results compared",
             sent, phases + 1, checked);
    $display("covered zero and full-scale limits, alarm entry and exit, stalls");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_keypad_code_lock_with_alarm: done, clean");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("tb_keypad_code_lock_with_alarm: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/kcl_pkg.sv
hw/rtl/kcl_cfg.sv
hw/rtl/kcl_core.sv
hw/rtl/keypad_code_lock_with_alarm.sv
bench/kcl_result_check.sv
bench/tb_keypad_code_lock_with_alarm.sv
